// ===== sv/sfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the substring first-match core
// Widths, command codes and the structs passed between the cells, the output
// buffer and the top level.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;

  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int START_W = 12;
  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int POS_W   = $clog2(TEXT_MAX + 1);
  localparam int CALC_A  = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int CALC_W  = (CALC_A > START_W) ? CALC_A : START_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_t;

  // broadcast to every cell
  typedef struct packed {
    logic              restart;
    logic              shift;
    logic              load;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               overflow;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/sfm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_cell: one pattern position of the match chain
// Holds one pattern byte and one match-progress bit; takes the progress bit of
// its left neighbour each text byte.
// ----------------------------------------------------------------------------
module sfm_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfm_pkg::cell_ctrl_t ctrl,
  input  wire logic               sel,
  input  wire logic               active,
  input  wire logic               last,
  input  wire logic               prev,
  output logic                    prog,
  output logic                    hit
);
  import sfm_pkg::*;

  logic [BYTE_W-1:0] pat;
  logic              prog_next;

  assign prog_next = active & prev & (pat == ctrl.data);
  assign hit       = last & prog_next;

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      pat <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      prog <= 1'b0;
    end else if (ctrl.shift) begin
      prog <= prog_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfm_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_out_buf: output register with skid stage
// Holds up to two results so the input side keeps running while the output
// is stalled.
// ----------------------------------------------------------------------------
module sfm_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sfm_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sfm_pkg::result_t      out_data
);
  import sfm_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid & ~out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/substring_first_match_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// substring_first_match_core: earliest match of a stored pattern in a text
// Pattern is loaded byte by byte into a chain of cells; text is streamed and
// one result is given per text.
// ----------------------------------------------------------------------------
// Takes one item per clock unless in_stall: pattern clear, pattern append or
// text byte. Every unsaturated text byte updates all pattern cells together,
// so the rate is one item per cycle whatever the pattern length. A text's
// result is registered in the output register (or skid stage if it is held)
// as its last byte is taken; in_stall rises only when both hold results.
module substring_first_match_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sfm_pkg::CMD_W-1:0]     command,
  input  wire logic [sfm_pkg::BYTE_W-1:0]    byte_value,
  input  wire logic                          end_of_text,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic [sfm_pkg::START_W-1:0]        match_start,
  output logic                               overflow
);
  import sfm_pkg::*;

  logic [LEN_W-1:0]       pat_len;
  logic [LEN_W-1:0]       pat_len_next;
  logic [POS_W-1:0]       text_pos;
  logic [POS_W-1:0]       text_pos_next;
  logic                   hit_seen;
  logic                   hit_seen_next;
  logic [START_W-1:0]     hit_start;
  logic [START_W-1:0]     hit_start_next;
  logic                   ovf_seen;
  logic                   ovf_seen_next;

  logic                   acc;
  logic                   saturated;
  logic                   hit_now;
  logic [CALC_W-1:0]      start_calc;
  logic                   push;
  cell_ctrl_t             ctrl;
  result_t                res;
  result_t                out_data;
  logic                   buf_full;

  logic [PATTERN_MAX-1:0] prog;
  logic [PATTERN_MAX-1:0] hits;
  logic [PATTERN_MAX-1:0] prev;

  assign acc       = in_valid & ~in_stall;
  assign in_stall  = buf_full;
  assign saturated = (text_pos >= POS_W'(TEXT_MAX));
  assign hit_now   = |hits;
  assign start_calc = CALC_W'(text_pos) + CALC_W'(1) - CALC_W'(pat_len);

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev[gi] = 1'b1;
      end else begin : g_link
        assign prev[gi] = prog[gi-1];
      end
      sfm_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .sel    (pat_len == LEN_W'(gi)),
        .active (pat_len > LEN_W'(gi)),
        .last   (pat_len == LEN_W'(gi + 1)),
        .prev   (prev[gi]),
        .prog   (prog[gi]),
        .hit    (hits[gi])
      );
    end
  endgenerate

  always_comb begin
    pat_len_next   = pat_len;
    text_pos_next  = text_pos;
    hit_seen_next  = hit_seen;
    hit_start_next = hit_start;
    ovf_seen_next  = ovf_seen;
    ctrl.restart   = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.data      = byte_value;
    push           = 1'b0;
    if (acc) begin
      case (cmd_t'(command))
        CMD_CLEAR: begin
          pat_len_next  = '0;
          ovf_seen_next = 1'b0;
          ctrl.restart  = 1'b1;
        end
        CMD_APPEND: begin
          if (pat_len < LEN_W'(PATTERN_MAX)) begin
            pat_len_next = pat_len + LEN_W'(1);
            ctrl.load    = 1'b1;
          end else begin
            ovf_seen_next = 1'b1;
          end
          ctrl.restart = 1'b1;
        end
        CMD_TEXT: begin
          if (saturated) begin
            ovf_seen_next = 1'b1;
          end else begin
            ctrl.shift    = 1'b1;
            text_pos_next = text_pos + POS_W'(1);
            if (hit_now && !hit_seen) begin
              hit_seen_next  = 1'b1;
              hit_start_next = start_calc[START_W-1:0];
            end
          end
          if (end_of_text) begin
            push = 1'b1;
            ctrl.restart = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.found       = hit_seen_next;
    res.match_start = hit_seen_next ? hit_start_next : '0;
    res.overflow    = ovf_seen_next;
    if (ctrl.restart) begin
      text_pos_next  = '0;
      hit_seen_next  = 1'b0;
      hit_start_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      text_pos  <= '0;
      hit_seen  <= 1'b0;
      hit_start <= '0;
      ovf_seen  <= 1'b0;
    end else begin
      pat_len   <= pat_len_next;
      text_pos  <= text_pos_next;
      hit_seen  <= hit_seen_next;
      hit_start <= hit_start_next;
      ovf_seen  <= ovf_seen_next;
    end
  end

  sfm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign found       = out_data.found;
  assign match_start = out_data.match_start;
  assign overflow    = out_data.overflow;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid stage full with empty output register");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pat_len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    text_pos <= POS_W'(TEXT_MAX))
    else $error("text position beyond saturation");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && command == CMD_CLEAR) |=> (pat_len == '0 && prog == '0 && !ovf_seen))
    else $error("clear left pattern or progress state");

  a_progress_in_range: assert property (@(posedge clk) disable iff (rst)
    (pat_len < LEN_W'(PATTERN_MAX)) |-> ((prog >> pat_len) == '0))
    else $error("progress bit set beyond pattern length");

endmodule
`default_nettype wire
